FILE: hw/rtl/vector_console_channel_decoder_macros.svh
// ----------------------------------------------------------------------------
// Vector console channel decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_CONSOLE_CHANNEL_DECODER_MACROS_SVH
`define VECTOR_CONSOLE_CHANNEL_DECODER_MACROS_SVH

// Same-cycle implication.
`define VCCD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VCCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/vccd_pkg.sv
// ----------------------------------------------------------------------------
// Vector console channel decoder package
// Command, result and function codes, lookup tables and shared types.
// ----------------------------------------------------------------------------
package vccd_pkg;

	localparam int HISTORY_DEPTH_DEF = 5;

	// channel commands
	localparam logic [1:0] CMD_FUNC  = 2'd0;
	localparam logic [1:0] CMD_DATA  = 2'd1;
	localparam logic [1:0] CMD_KEYIN = 2'd2;

	// result kinds
	localparam logic [3:0] KIND_STATUS = 4'd0;
	localparam logic [3:0] KIND_SCREEN = 4'd1;
	localparam logic [3:0] KIND_FONT   = 4'd2;
	localparam logic [3:0] KIND_SET_X  = 4'd3;
	localparam logic [3:0] KIND_SET_Y  = 4'd4;
	localparam logic [3:0] KIND_CHAR   = 4'd5;
	localparam logic [3:0] KIND_DOT    = 4'd6;
	localparam logic [3:0] KIND_KEY    = 4'd7;
	localparam logic [3:0] KIND_FOUND  = 4'd8;

	localparam logic [8:0] STATUS_ACCEPT  = 9'd0;
	localparam logic [8:0] STATUS_DECLINE = 9'd1;

	// function codes
	localparam logic [11:0] FN_SEL_L_DOT   = 12'o7000;
	localparam logic [11:0] FN_SEL_L_SMALL = 12'o7001;
	localparam logic [11:0] FN_SEL_L_MED   = 12'o7002;
	localparam logic [11:0] FN_DOT_L       = 12'o7010;
	localparam logic [11:0] FN_DOT_R       = 12'o7110;
	localparam logic [11:0] FN_KEYIN       = 12'o7020;
	localparam logic [11:0] FN_SEL_R_SMALL = 12'o7100;
	localparam logic [11:0] FN_SEL_R_MED   = 12'o7101;
	localparam logic [11:0] FN_SEL_R_LARGE = 12'o7102;

	// function modes
	localparam logic [3:0] MODE_NONE        = 4'd0;
	localparam logic [3:0] MODE_SEL_L_DOT   = 4'd1;
	localparam logic [3:0] MODE_SEL_L_SMALL = 4'd2;
	localparam logic [3:0] MODE_SEL_L_MED   = 4'd3;
	localparam logic [3:0] MODE_DOT_L       = 4'd4;
	localparam logic [3:0] MODE_DOT_R       = 4'd5;
	localparam logic [3:0] MODE_KEYIN       = 4'd6;
	localparam logic [3:0] MODE_SEL_R_SMALL = 4'd7;
	localparam logic [3:0] MODE_SEL_R_MED   = 4'd8;
	localparam logic [3:0] MODE_SEL_R_LARGE = 4'd9;

	// upper six bits of a data word: coordinate thresholds
	localparam logic [5:0] HI_SET_Y = 6'o70;
	localparam logic [5:0] HI_SET_X = 6'o60;

	localparam logic [15:0] INC_LARGE = 16'd32;

	typedef struct packed {
		logic [3:0] kind;
		logic [8:0] value;
	} result_t;

	typedef struct packed {
		logic [31:0] high;
		logic [31:0] low;
	} hist_entry_t;

	function automatic logic [3:0] fn_lookup(input logic [11:0] code);
		logic [3:0] m;
		case (code)
			FN_SEL_L_DOT:   m = MODE_SEL_L_DOT;
			FN_SEL_L_SMALL: m = MODE_SEL_L_SMALL;
			FN_SEL_L_MED:   m = MODE_SEL_L_MED;
			FN_DOT_L:       m = MODE_DOT_L;
			FN_DOT_R:       m = MODE_DOT_R;
			FN_KEYIN:       m = MODE_KEYIN;
			FN_SEL_R_SMALL: m = MODE_SEL_R_SMALL;
			FN_SEL_R_MED:   m = MODE_SEL_R_MED;
			FN_SEL_R_LARGE: m = MODE_SEL_R_LARGE;
			default:        m = MODE_NONE;
		endcase
		return m;
	endfunction

	function automatic logic [1:0] fn_screen(input logic [3:0] m);
		logic [1:0] s;
		case (m)
			MODE_DOT_R, MODE_SEL_R_SMALL, MODE_SEL_R_MED, MODE_SEL_R_LARGE: s = 2'd1;
			default: s = 2'd0;
		endcase
		return s;
	endfunction

	// left select codes carry the font one size above their labels
	function automatic logic [1:0] fn_font(input logic [3:0] m);
		logic [1:0] f;
		case (m)
			MODE_SEL_L_DOT, MODE_SEL_R_SMALL:   f = 2'd1;
			MODE_SEL_L_SMALL, MODE_SEL_R_MED:   f = 2'd2;
			MODE_SEL_L_MED, MODE_SEL_R_LARGE:   f = 2'd3;
			default:                            f = 2'd0;
		endcase
		return f;
	endfunction

	function automatic logic [15:0] font_inc(input logic [1:0] f);
		logic [15:0] inc;
		case (f)
			2'd0:    inc = 16'd1;
			2'd1:    inc = 16'd8;
			2'd2:    inc = 16'd16;
			default: inc = INC_LARGE;
		endcase
		return inc;
	endfunction

endpackage

FILE: hw/rtl/vccd_hist_ram.sv
// ----------------------------------------------------------------------------
// Sum history memory
// One write and one registered read port; entries read as zero until written.
// ----------------------------------------------------------------------------
module vccd_hist_ram import vccd_pkg::*; #(
	parameter int DEPTH = HISTORY_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [AW-1:0] wr_addr,
	input  hist_entry_t wr_data,
	input  logic [AW-1:0] rd_addr,
	output hist_entry_t rd_data
);

	hist_entry_t      mem_q [DEPTH];
	hist_entry_t      rd_raw_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_raw_q <= mem_q[rd_addr];
	end

	// track written entries so reset reads back as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

FILE: hw/rtl/vector_console_channel_decoder.sv
// ----------------------------------------------------------------------------
// Vector console channel decoder
// Decodes channel function codes, data words and key-in polls into display
// results, with a Fletcher-style sum history for refresh cycle detection.
// ----------------------------------------------------------------------------
// One channel transaction is taken at a time: in_ready is high only while the
// sequencer is idle. The sequencer decodes it, then loads each result in turn
// into the single output register, which holds it while out_ready stalls. A
// function code or data word that feeds the sum history passes first through
// the memory read, low-sum add and high-sum add (on the one shared 32-bit
// adder). A key-in poll reads the current entry, then compares n earlier
// history entries, one per cycle through the history memory's single read
// port (n is at most HISTORY_DEPTH - 1), before its results are loaded.
// The next transaction is taken in the cycle after the last result is loaded.
// The history memory needs no clearing pass after reset.
module vector_console_channel_decoder import vccd_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [11:0] word,
	input  logic [5:0] key_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] kind,
	output logic [8:0] value,
	output logic       last
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b00_0000_0001,
		ST_DECODE  = 10'b00_0000_0010,
		ST_SUM_RD  = 10'b00_0000_0100,
		ST_SUM_LO  = 10'b00_0000_1000,
		ST_SUM_HI  = 10'b00_0001_0000,
		ST_KEY_RD  = 10'b00_0010_0000,
		ST_KEY_CUR = 10'b00_0100_0000,
		ST_KEY_CMP = 10'b00_1000_0000,
		ST_KEY_END = 10'b01_0000_0000,
		ST_EMIT    = 10'b10_0000_0000
	} state_t;

	state_t      state_q;

	// latched transaction
	logic [1:0]  cmd_q;
	logic [11:0] word_q;
	logic [5:0]  key_q;

	// console state
	logic [3:0]  mode_q;
	logic [1:0]  screen_q;
	logic [1:0]  font_q;
	logic [15:0] x_q;
	logic [AW-1:0] hidx_q;

	// sequencer working registers
	logic [8:0]  datum_q;
	logic [31:0] low_q;
	hist_entry_t cur_q;
	logic [AW-1:0] srch_q;
	logic        found_q;
	result_t     res_q [3];
	logic [1:0]  res_cnt_q;
	logic [1:0]  res_idx_q;

	// output register
	logic        out_valid_q;
	result_t     out_res_q;
	logic        out_last_q;

	// history memory ports
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	hist_entry_t wr_data;
	logic [AW-1:0] rd_addr;
	hist_entry_t rd_data;

	// shared adder
	logic [31:0] add_a;
	logic [31:0] add_b;
	logic [31:0] add_sum;
	logic [15:0] x_inc;

	// decode results
	result_t     dres [3];
	logic [1:0]  dcnt;
	logic        dsum;
	logic        dkey;
	logic [8:0]  ddatum;
	logic [3:0]  dmode;
	logic [1:0]  dscreen;
	logic [1:0]  dfont;
	logic        dx_load;
	logic        dx_adv;
	logic        dx_twice;

	logic        hit;
	logic        emit_load;
	logic        emit_last;
	logic [AW:0] hidx_inc;

	vccd_hist_ram #(
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign kind      = out_res_q.kind;
	assign value     = out_res_q.value;
	assign last      = out_last_q;

	assign hit      = (rd_data == cur_q);
	assign hidx_inc = {1'b0, hidx_q} + 1'b1;

	// Decode the latched transaction against the current console state.
	always_comb begin
		logic [3:0]  m;
		logic [1:0]  s;
		logic [1:0]  f;
		logic [5:0]  hi;
		logic [8:0]  coord;
		logic        dot;
		logic [1:0]  n;
		m        = fn_lookup(word_q);
		s        = fn_screen(m);
		f        = fn_font(m);
		hi       = word_q[11:6];
		coord    = word_q[8:0];
		dot      = (mode_q == MODE_DOT_L) || (mode_q == MODE_DOT_R);
		n        = 2'd0;
		dres     = '{default: '0};
		dsum     = 1'b0;
		dkey     = 1'b0;
		ddatum   = '0;
		dmode    = mode_q;
		dscreen  = screen_q;
		dfont    = font_q;
		dx_load  = 1'b0;
		dx_adv   = 1'b0;
		dx_twice = 1'b0;
		case (cmd_q)
			CMD_FUNC: begin
				if (m == MODE_NONE) begin
					dres[n] = '{kind: KIND_STATUS, value: STATUS_DECLINE};
					n = n + 2'd1;
				end else begin
					if (m != MODE_KEYIN) begin
						if (screen_q != s) begin
							dsum    = 1'b1;
							ddatum  = 9'(s);
							dres[n] = '{kind: KIND_SCREEN, value: 9'(s)};
							n = n + 2'd1;
						end
						if (font_q != f) begin
							dres[n] = '{kind: KIND_FONT, value: 9'(f)};
							n = n + 2'd1;
						end
						dscreen = s;
						dfont   = f;
					end
					dmode   = m;
					dres[n] = '{kind: KIND_STATUS, value: STATUS_ACCEPT};
					n = n + 2'd1;
				end
			end
			CMD_DATA: begin
				if (mode_q != MODE_NONE && mode_q != MODE_KEYIN) begin
					if (hi >= HI_SET_Y) begin
						dsum    = 1'b1;
						ddatum  = coord;
						dres[n] = '{kind: KIND_SET_Y, value: coord};
						n = n + 2'd1;
						if (dot) begin
							dres[n] = '{kind: KIND_DOT, value: x_q[8:0]};
							n = n + 2'd1;
							dx_adv  = 1'b1;
						end
					end else if (hi >= HI_SET_X) begin
						dsum    = 1'b1;
						ddatum  = coord;
						dx_load = 1'b1;
						dres[n] = '{kind: KIND_SET_X, value: coord};
						n = n + 2'd1;
					end else if (!dot) begin
						// two display codes, X advances once for each
						dres[0]  = '{kind: KIND_CHAR, value: 9'(hi)};
						dres[1]  = '{kind: KIND_CHAR, value: 9'(word_q[5:0])};
						n        = 2'd2;
						dx_adv   = 1'b1;
						dx_twice = 1'b1;
					end
				end
			end
			CMD_KEYIN: begin
				dkey = (mode_q == MODE_KEYIN);
			end
			default: begin
			end
		endcase
		dcnt = n;
	end

	assign x_inc = font_inc(font_q);

	// Shared adder operand selection.
	always_comb begin
		add_a = '0;
		add_b = '0;
		case (state_q)
			ST_DECODE: begin
				add_a = {16'd0, x_q};
				add_b = {16'd0, dx_twice ? {x_inc[14:0], 1'b0} : x_inc};
			end
			ST_SUM_LO: begin
				add_a = rd_data.low;
				add_b = {23'd0, datum_q};
			end
			ST_SUM_HI: begin
				add_a = rd_data.high;
				add_b = low_q;
			end
			default: begin
			end
		endcase
	end

	assign add_sum = add_a + add_b;

	// History memory addressing.
	always_comb begin
		rd_addr = hidx_q;
		wr_en   = 1'b0;
		wr_addr = hidx_q;
		wr_data = '{high: add_sum, low: low_q};
		case (state_q)
			ST_KEY_CUR: rd_addr = hidx_q - AW'(1);
			ST_KEY_CMP: rd_addr = srch_q - AW'(1);
			ST_SUM_HI:  wr_en   = 1'b1;
			ST_KEY_END: begin
				// restart at entry 0 on a hit, else open the next entry if any
				wr_data = '0;
				if (found_q) begin
					wr_en   = 1'b1;
					wr_addr = '0;
				end else if (hidx_inc < DEPTH_W) begin
					wr_en   = 1'b1;
					wr_addr = hidx_inc[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign emit_last = (res_idx_q == res_cnt_q - 2'd1) || (res_cnt_q == 2'd0);

	// Sequencer and console state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= MODE_NONE;
			screen_q  <= 2'd3;
			font_q    <= 2'd1;
			x_q       <= '0;
			hidx_q    <= '0;
			res_cnt_q <= '0;
			res_idx_q <= '0;
			found_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					mode_q    <= dmode;
					screen_q  <= dscreen;
					font_q    <= dfont;
					res_cnt_q <= dcnt;
					res_idx_q <= '0;
					if (dx_load) begin
						x_q <= {7'd0, word_q[8:0]};
					end else if (dx_adv) begin
						x_q <= add_sum[15:0];
					end
					if (dkey) begin
						state_q <= ST_KEY_RD;
					end else if (dsum) begin
						state_q <= ST_SUM_RD;
					end else if (dcnt != 2'd0) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SUM_RD: state_q <= ST_SUM_LO;
				ST_SUM_LO: state_q <= ST_SUM_HI;
				ST_SUM_HI: state_q <= ST_EMIT;
				ST_KEY_RD: state_q <= ST_KEY_CUR;
				ST_KEY_CUR: begin
					found_q <= 1'b0;
					if (hidx_q == '0) begin
						state_q <= ST_KEY_END;
					end else begin
						state_q <= ST_KEY_CMP;
					end
				end
				ST_KEY_CMP: begin
					// walk back from the newest earlier entry, stop on first match
					if (hit) begin
						found_q <= 1'b1;
						state_q <= ST_KEY_END;
					end else if (srch_q == '0) begin
						state_q <= ST_KEY_END;
					end
				end
				ST_KEY_END: begin
					mode_q    <= MODE_NONE;
					res_idx_q <= '0;
					res_cnt_q <= found_q ? 2'd2 : 2'd1;
					if (found_q) begin
						hidx_q <= '0;
					end else if (hidx_inc < DEPTH_W) begin
						hidx_q <= hidx_inc[AW-1:0];
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						res_idx_q <= res_idx_q + 2'd1;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q  <= command;
				word_q <= word;
				key_q  <= key_code;
			end
			ST_DECODE: begin
				res_q   <= dres;
				datum_q <= ddatum;
			end
			ST_SUM_LO: low_q <= add_sum;
			ST_KEY_CUR: begin
				cur_q  <= rd_data;
				srch_q <= hidx_q - AW'(1);
			end
			ST_KEY_CMP: begin
				if (!hit && srch_q != '0) begin
					srch_q <= srch_q - AW'(1);
				end
			end
			ST_KEY_END: begin
				if (found_q) begin
					res_q[0] <= '{kind: KIND_FOUND, value: 9'(srch_q)};
					res_q[1] <= '{kind: KIND_KEY, value: 9'(key_q)};
				end else begin
					res_q[0] <= '{kind: KIND_KEY, value: 9'(key_q)};
				end
			end
			default: begin
			end
		endcase
		if (emit_load) begin
			out_res_q  <= res_q[res_idx_q];
			out_last_q <= emit_last;
		end
	end

	// Hold a result until taken, drop valid once accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/vccd_checker.sv
// ----------------------------------------------------------------------------
// Vector console channel decoder checker
// Port-level assertions on result ordering and the input and output handshakes.
// ----------------------------------------------------------------------------
`include "vector_console_channel_decoder_macros.svh"

module vccd_checker import vccd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] kind,
	input logic [8:0] value,
	input logic       last
);

	`VCCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(value) && $stable(last), "stalled result changed")
	`VCCD_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "transaction taken while busy")
	`VCCD_ASSERT_IMPL(a_status_last, out_valid && (kind == KIND_STATUS || kind == KIND_KEY), last, "status or key reply not final")
	`VCCD_ASSERT_IMPL(a_found_not_last, out_valid && kind == KIND_FOUND, !last, "cycle found not followed by key reply")

endmodule

bind vector_console_channel_decoder vccd_checker u_vccd_checker (.*);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Vector console channel decoder testbench
// Sends function codes, data words and key-in polls over the channel
// handshake. A local model of the console predicts every display result,
// and each result is checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import vccd_pkg::*;

	localparam int DEPTH = HISTORY_DEPTH_DEF;

	// command code that the channel never uses
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] SCR_LEFT    = 2'd0;
	localparam logic [1:0] SCR_RIGHT   = 2'd1;
	localparam logic [1:0] SCR_UNKNOWN = 2'd3;

	localparam logic [1:0] FONT_DOT   = 2'd0;
	localparam logic [1:0] FONT_SMALL = 2'd1;
	localparam logic [1:0] FONT_MED   = 2'd2;
	localparam logic [1:0] FONT_LARGE = 2'd3;

	// a key-in poll with a full history compare is the slowest transaction
	localparam int SETTLE_CYCLES = 32;
	localparam int TIMEOUT_NS    = 5_000_000;
	localparam int MAX_REPORTS   = 40;

	typedef struct packed {
		logic [3:0] kind;
		logic [8:0] value;
		logic       last;
	} display_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [11:0] wd;
		logic [5:0]  key;
	} chan_item_t;

	// ------------------------------------------------------------------------
	// Clock, reset and DUT ports; every input is known from time zero
	// ------------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [1:0]  command   = CMD_FUNC;
	logic [11:0] word      = '0;
	logic [5:0]  key_code  = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  kind;
	logic [8:0]  value;
	logic        last;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	vector_console_channel_decoder #(
		.HISTORY_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.word     (word),
		.key_code (key_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind     (kind),
		.value    (value),
		.last     (last)
	);

	// ------------------------------------------------------------------------
	// Console model state
	// ------------------------------------------------------------------------
	logic        console_active;   // a function is selected
	logic [11:0] console_func;     // the accepted function code
	logic [1:0]  console_screen;
	logic [1:0]  console_font;
	logic [15:0] beam_x;
	logic [8:0]  beam_y;
	logic [31:0] sum_lo [DEPTH];
	logic [31:0] sum_hi [DEPTH];
	int          hist_idx;

	display_t    expected_q [$];
	chan_item_t  frame_q [$];

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int results_checked;
	int cycles_found;
	int full_polls;
	int err_count;

	function automatic void push_display(input logic [3:0] k, input logic [8:0] v);
		display_t d;
		d.kind  = k;
		d.value = v;
		d.last  = 1'b0;
		expected_q.push_back(d);
	endfunction

	function automatic logic [15:0] x_step(input logic [1:0] f);
		case (f)
			FONT_DOT:   return 16'd1;
			FONT_SMALL: return 16'd8;
			FONT_MED:   return 16'd16;
			default:    return 16'd32;
		endcase
	endfunction

	// Fletcher-style pair on the current history entry
	function automatic void feed_sums(input logic [31:0] d);
		sum_lo[hist_idx] = sum_lo[hist_idx] + d;
		sum_hi[hist_idx] = sum_hi[hist_idx] + sum_lo[hist_idx];
	endfunction

	// Known codes return 1 with the screen and font they select. The left
	// select codes carry the font one size above their labels.
	function automatic bit decode_func(input logic [11:0] code,
			output logic [1:0] scr, output logic [1:0] fnt);
		scr = SCR_LEFT;
		fnt = FONT_DOT;
		case (code)
			FN_SEL_L_DOT:   fnt = FONT_SMALL;
			FN_SEL_L_SMALL: fnt = FONT_MED;
			FN_SEL_L_MED:   fnt = FONT_LARGE;
			FN_DOT_L:       fnt = FONT_DOT;
			FN_DOT_R:       scr = SCR_RIGHT;
			FN_SEL_R_SMALL: begin
				scr = SCR_RIGHT;
				fnt = FONT_SMALL;
			end
			FN_SEL_R_MED: begin
				scr = SCR_RIGHT;
				fnt = FONT_MED;
			end
			FN_SEL_R_LARGE: begin
				scr = SCR_RIGHT;
				fnt = FONT_LARGE;
			end
			FN_KEYIN: ;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// Advance the console model by one transaction and queue its results.
	function automatic void predict_console(input chan_item_t it);
		int         n0;
		int         cur;
		int         i;
		bit         known;
		bit         dot;
		bit         found;
		logic [1:0] scr;
		logic [1:0] fnt;
		logic [5:0] hi6;
		logic [8:0] coord;
		n0 = expected_q.size();
		case (it.cmd)
			CMD_FUNC: begin
				known = decode_func(it.wd, scr, fnt);
				if (!known) begin
					// decline and leave all state alone
					push_display(KIND_STATUS, STATUS_DECLINE);
				end else begin
					if (it.wd != FN_KEYIN) begin
						if (console_screen != scr) begin
							feed_sums({30'd0, scr});
							push_display(KIND_SCREEN, {7'd0, scr});
							console_screen = scr;
						end
						if (console_font != fnt) begin
							push_display(KIND_FONT, {7'd0, fnt});
							console_font = fnt;
						end
					end
					console_active = 1'b1;
					console_func   = it.wd;
					push_display(KIND_STATUS, STATUS_ACCEPT);
				end
			end
			CMD_DATA: begin
				if (console_active && console_func != FN_KEYIN) begin
					hi6   = it.wd[11:6];
					coord = it.wd[8:0];
					dot   = (console_func == FN_DOT_L) || (console_func == FN_DOT_R);
					if (hi6 >= HI_SET_Y) begin
						feed_sums({23'd0, coord});
						beam_y = coord;
						push_display(KIND_SET_Y, coord);
						if (dot) begin
							push_display(KIND_DOT, beam_x[8:0]);
							beam_x = beam_x + x_step(console_font);
						end
					end else if (hi6 >= HI_SET_X) begin
						feed_sums({23'd0, coord});
						beam_x = {7'd0, coord};
						push_display(KIND_SET_X, coord);
					end else if (!dot) begin
						// both display codes go out, whatever their value
						push_display(KIND_CHAR, {3'd0, hi6});
						beam_x = beam_x + x_step(console_font);
						push_display(KIND_CHAR, {3'd0, it.wd[5:0]});
						beam_x = beam_x + x_step(console_font);
					end
				end
			end
			CMD_KEYIN: begin
				if (console_active && console_func == FN_KEYIN) begin
					cur   = hist_idx;
					found = 1'b0;
					for (i = cur - 1; i >= 0 && !found; i--) begin
						if (sum_lo[i] == sum_lo[cur] && sum_hi[i] == sum_hi[cur]) begin
							found = 1'b1;
							push_display(KIND_FOUND, 9'(i));
						end
					end
					if (found) begin
						hist_idx  = 0;
						sum_lo[0] = '0;
						sum_hi[0] = '0;
						cycles_found++;
					end else if (cur + 1 < DEPTH) begin
						hist_idx        = cur + 1;
						sum_lo[cur + 1] = '0;
						sum_hi[cur + 1] = '0;
					end else begin
						// full: stay on the last entry and keep summing into it
						full_polls++;
					end
					console_active = 1'b0;
					push_display(KIND_KEY, {3'd0, it.key});
				end
			end
			default: ;
		endcase
		if (expected_q.size() > n0)
			expected_q[expected_q.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [11:0] side_code(input logic side);
		logic [1:0] pick;
		pick = 2'($urandom_range(0, 3));
		if (!side) begin
			case (pick)
				2'd0:    return FN_SEL_L_DOT;
				2'd1:    return FN_SEL_L_SMALL;
				2'd2:    return FN_SEL_L_MED;
				default: return FN_DOT_L;
			endcase
		end else begin
			case (pick)
				2'd0:    return FN_DOT_R;
				2'd1:    return FN_SEL_R_SMALL;
				2'd2:    return FN_SEL_R_MED;
				default: return FN_SEL_R_LARGE;
			endcase
		end
	endfunction

	// character pair, X coordinate or Y coordinate, evenly
	function automatic logic [11:0] rand_data_word();
		case ($urandom_range(0, 2))
			0:       return 12'($urandom_range(0, 12'o5777));
			1:       return 12'o6000 | 12'($urandom_range(0, 511));
			default: return 12'o7000 | 12'($urandom_range(0, 511));
		endcase
	endfunction

	function automatic logic [5:0] rand_key();
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic void add_frame_words(input int n);
		chan_item_t it;
		repeat (n) begin
			it.cmd = CMD_DATA;
			it.wd  = rand_data_word();
			it.key = rand_key();
			frame_q.push_back(it);
		end
	endfunction

	// Drive one transaction at the falling edge, hold it until the rising
	// edge that takes it, then advance the model.
	task automatic send_item(input logic [1:0] c, input logic [11:0] w,
			input logic [5:0] k);
		chan_item_t it;
		it.cmd = c;
		it.wd  = w;
		it.key = k;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		command  = c;
		word     = w;
		key_code = k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_console(it);
		items_sent++;
	endtask

	// select key-in, then run the input cycle
	task automatic send_poll();
		logic [5:0] k;
		k = rand_key();
		send_item(CMD_FUNC, FN_KEYIN, k);
		send_item(CMD_KEYIN, 12'($urandom), k);
	endtask

	task automatic play_frame();
		foreach (frame_q[i])
			send_item(frame_q[i].cmd, frame_q[i].wd, frame_q[i].key);
	endtask

	// Hold the channel idle until every queued result is back, then give the
	// block time to finish any transaction that produced nothing.
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_decode_directed();
		// nothing selected yet: data and input cycles drop, command 3 drops
		send_item(CMD_DATA, 12'o7777, 6'd0);
		send_item(CMD_KEYIN, 12'o0000, 6'd5);
		send_item(CMD_UNUSED, 12'o0000, 6'd63);
		// key-in select: accepted with no screen or font change
		send_item(CMD_FUNC, FN_KEYIN, 6'd0);
		send_item(CMD_DATA, 12'o1234, 6'd0);
		// first poll has nothing to compare; the second finds two empty sums
		send_item(CMD_KEYIN, 12'o7777, 6'd0);
		send_item(CMD_FUNC, FN_KEYIN, 6'd0);
		send_item(CMD_KEYIN, 12'o0000, 6'd63);
		// unknown codes are declined
		send_item(CMD_FUNC, 12'o0000, 6'd0);
		send_item(CMD_FUNC, 12'o7777, 6'd0);
		send_item(CMD_FUNC, 12'o7003, 6'd0);
		// screen leaves the unknown state, font steps through the sizes
		send_item(CMD_FUNC, FN_SEL_L_DOT, 6'd0);
		send_item(CMD_FUNC, FN_SEL_L_SMALL, 6'd0);
		send_item(CMD_DATA, 12'o0000, 6'd0);
		send_item(CMD_DATA, 12'o5777, 6'd0);
		send_item(CMD_FUNC, FN_SEL_L_MED, 6'd0);
		send_item(CMD_DATA, 12'o6000, 6'd0);
		send_item(CMD_DATA, 12'o6777, 6'd0);
		send_item(CMD_DATA, 12'o7000, 6'd0);
		send_item(CMD_DATA, 12'o7777, 6'd0);
		// dot mode: display codes drop, Y plots a dot
		send_item(CMD_FUNC, FN_DOT_L, 6'd0);
		send_item(CMD_DATA, 12'o5757, 6'd0);
		send_item(CMD_DATA, 12'o7123, 6'd0);
		send_item(CMD_FUNC, FN_DOT_R, 6'd0);
		send_item(CMD_DATA, 12'o7777, 6'd0);
		send_item(CMD_FUNC, FN_SEL_R_SMALL, 6'd0);
		send_item(CMD_FUNC, FN_SEL_R_MED, 6'd0);
		send_item(CMD_FUNC, FN_SEL_R_LARGE, 6'd0);
		send_item(CMD_DATA, 12'o2525, 6'd0);
	endtask

	// Redraw one frame on a single screen, polling after each pass, so that
	// the history sees the same sum pair again and flags a refresh cycle.
	task automatic test_refresh_detection(input int n_items);
		int         stop;
		logic       side;
		chan_item_t it;
		stop = items_sent + n_items;
		while (items_sent < stop) begin
			side = 1'($urandom_range(0, 1));
			frame_q.delete();
			it.cmd = CMD_FUNC;
			it.wd  = side_code(side);
			it.key = rand_key();
			frame_q.push_back(it);
			add_frame_words($urandom_range(1, 5));
			if ($urandom_range(0, 1)) begin
				it.wd = side_code(side);
				frame_q.push_back(it);
				add_frame_words($urandom_range(1, 3));
			end
			// settle the screen first so every pass starts from the same state
			send_item(CMD_FUNC, side_code(side), rand_key());
			send_poll();
			repeat ($urandom_range(2, 3)) begin
				play_frame();
				send_poll();
			end
		end
	endtask

	// Random commands, codes and words; key-in commands are sent, but the key-in
	// code is never picked on purpose, so the history keeps its refresh detection for the next phase.
	task automatic test_channel_noise(input int n_items);
		logic [1:0]  c;
		logic [11:0] w;
		repeat (n_items) begin
			c = 2'($urandom_range(0, 3));
			if (c == CMD_FUNC && $urandom_range(0, 1))
				w = side_code(1'($urandom_range(0, 1)));
			else if (c == CMD_DATA && $urandom_range(0, 1))
				w = rand_data_word();
			else
				w = 12'($urandom);
			send_item(c, w, rand_key());
		end
	endtask

	// Distinct frames with a poll after each fill the history until it
	// stays on its last entry.
	task automatic test_history_overflow(input int n_polls);
		repeat (n_polls) begin
			send_item(CMD_FUNC, side_code(1'($urandom_range(0, 1))), rand_key());
			repeat ($urandom_range(1, 3))
				send_item(CMD_DATA, rand_data_word(), rand_key());
			send_poll();
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stall, then in-order compare
	// ------------------------------------------------------------------------
	always @(negedge clk)
		out_ready = ($urandom_range(0, 99) >= recv_idle_pct);

	task automatic note_mismatch(input string field, input logic [15:0] want,
			input logic [15:0] got);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin : check_results
		display_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: result kind %0d value %0d last %0d with none expected",
						$time, kind, value, last);
			end else begin
				want = expected_q.pop_front();
				results_checked++;
				if (kind !== want.kind)
					note_mismatch("kind", 16'(want.kind), 16'(kind));
				if (value !== want.value)
					note_mismatch("value", 16'(want.value), 16'(value));
				if (last !== want.last)
					note_mismatch("last", 16'(want.last), 16'(last));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin : run_tests
		console_active  = 1'b0;
		console_func    = '0;
		console_screen  = SCR_UNKNOWN;
		console_font    = FONT_SMALL;
		beam_x          = '0;
		beam_y          = '0;
		hist_idx        = 0;
		items_sent      = 0;
		results_checked = 0;
		cycles_found    = 0;
		full_polls      = 0;
		err_count       = 0;
		foreach (sum_lo[i]) begin
			sum_lo[i] = '0;
			sum_hi[i] = '0;
		end

		// sender idles lightly, receiver stalls about half the time
		send_idle_pct = 19;
		recv_idle_pct = 52;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_decode_directed();
		test_refresh_detection(55);
		test_channel_noise(25);
		wait_for_drain();

		// swap the pressure: a slow sender, a mostly ready receiver
		send_idle_pct = 52;
		recv_idle_pct = 19;
		test_refresh_detection(55);
		test_channel_noise(25);
		wait_for_drain();

		// back to back on both sides; fill the history last
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_refresh_detection(55);
		test_channel_noise(20);
		test_history_overflow(8);
		wait_for_drain();

		$display("Covered %0d channel transactions and %0d display results.",
			items_sent, results_checked);
		$display("Refresh cycles detected %0d times, polls on a full history %0d.",
			cycles_found, full_polls);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/vccd_pkg.sv
hw/rtl/vccd_hist_ram.sv
hw/rtl/vector_console_channel_decoder.sv
hw/rtl/vccd_checker.sv
dv/tb.sv
